>>> rtl/vfd_pkg.sv
`default_nettype none

package vfd_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int TABLE_WAYS  = 4;
	localparam int TABLE_SETS  = TABLE_DEPTH / TABLE_WAYS;
	localparam int SET_W       = $clog2(TABLE_SETS);
	localparam int WAY_W       = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;

	localparam int LEN_W  = 14;
	localparam int MAC_W  = 48;
	localparam int ETY_W  = 16;
	localparam int TCI_W  = 16;
	localparam int VID_W  = 12;
	localparam int PORT_W = 9;
	localparam int KEY_W  = VID_W + MAC_W;

	localparam logic [ETY_W-1:0] TPID_VLAN      = 16'h8100;
	localparam logic [TCI_W-1:0] VID_FIELD_MASK = 16'h0fff;
	localparam logic [LEN_W-1:0] ETH_HDR_BYTES  = 14'd14;
	localparam logic [LEN_W-1:0] TAG_BYTES      = 14'd4;

	localparam int HASH_SH1   = 20;
	localparam int HASH_SH2   = 40;
	localparam int HASH_SHIFT = 32;
	localparam int HASH_W     = HASH_SHIFT + SET_W;
	localparam int P_LO_W     = (HASH_W + 1) / 2;
	localparam int P_HI_W     = HASH_W - P_LO_W;
	localparam logic [63:0] HASH_MULT = 64'h9e3779b97f4a7c15;

	typedef enum logic [1:0] {
		VERDICT_PASS       = 2'd0,
		VERDICT_DROP       = 2'd1,
		VERDICT_REDIRECT   = 2'd2,
		VERDICT_WRITE_DONE = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_LOOK
	} state_t;

	typedef logic [SET_W-1:0] set_t;
	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic              kind;
		logic [LEN_W-1:0]  frame_length;
		logic [MAC_W-1:0]  dest_mac;
		logic [ETY_W-1:0]  outer_ethertype;
		logic [TCI_W-1:0]  tag_control;
		logic [ETY_W-1:0]  inner_ethertype;
		logic [VID_W-1:0]  write_vlan;
		logic [MAC_W-1:0]  write_mac;
		logic [PORT_W-1:0] write_port;
	} req_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [PORT_W-1:0] egress_port;
		logic [ETY_W-1:0]  new_ethertype;
		logic [LEN_W-1:0]  new_length;
		logic              table_full;
	} rsp_t;

	typedef struct packed {
		logic              vld;
		key_t              key;
		logic [PORT_W-1:0] port;
	} way_t;

	typedef way_t [TABLE_WAYS-1:0] row_t;

	typedef struct packed {
		logic rd_en;
		set_t rd_set;
		logic wr_en;
		set_t wr_set;
		row_t wr_row;
	} tbl_ctl_t;

endpackage

`default_nettype wire

>>> rtl/vfd_if.sv
`default_nettype none

interface vfd_req_if;
	logic          valid;
	logic          ready;
	vfd_pkg::req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface vfd_rsp_if;
	logic          valid;
	logic          ready;
	vfd_pkg::rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/vfd_hash.sv
`default_nettype none

module vfd_hash (
	input  wire logic          clk,
	input  wire logic          ld,
	input  wire vfd_pkg::key_t key,
	output vfd_pkg::set_t      set
);

	vfd_pkg::key_t                 h;
	logic [vfd_pkg::P_LO_W-1:0]    h_lo;
	logic [vfd_pkg::P_HI_W-1:0]    h_hi;
	logic [vfd_pkg::P_LO_W-1:0]    c_lo;
	logic [vfd_pkg::P_HI_W-1:0]    c_hi;
	logic [2*vfd_pkg::P_LO_W-1:0]  pp_ll_s1;
	logic [vfd_pkg::P_HI_W-1:0]    pp_hl_s1;
	logic [vfd_pkg::P_HI_W-1:0]    pp_lh_s1;
	logic [vfd_pkg::HASH_W-1:0]    sum;

	// fold, then low bits of the golden-ratio multiply as partial products
	assign h    = key ^ (key >> vfd_pkg::HASH_SH1) ^ (key >> vfd_pkg::HASH_SH2);
	assign h_lo = h[vfd_pkg::P_LO_W-1:0];
	assign h_hi = h[vfd_pkg::P_LO_W +: vfd_pkg::P_HI_W];
	assign c_lo = vfd_pkg::HASH_MULT[vfd_pkg::P_LO_W-1:0];
	assign c_hi = vfd_pkg::HASH_MULT[vfd_pkg::P_LO_W +: vfd_pkg::P_HI_W];

	always_ff @(posedge clk) begin
		if (ld) begin
			pp_ll_s1 <= (2*vfd_pkg::P_LO_W)'(h_lo) * (2*vfd_pkg::P_LO_W)'(c_lo);
			pp_hl_s1 <= h_hi * vfd_pkg::P_HI_W'(c_lo);
			pp_lh_s1 <= vfd_pkg::P_HI_W'(h_lo) * c_hi;
		end
	end

	assign sum = vfd_pkg::HASH_W'(pp_ll_s1)
		+ {pp_hl_s1 + pp_lh_s1, vfd_pkg::P_LO_W'(0)};
	assign set = sum[vfd_pkg::HASH_SHIFT +: vfd_pkg::SET_W];

endmodule

`default_nettype wire

>>> rtl/vfd_table.sv
`default_nettype none

module vfd_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire vfd_pkg::tbl_ctl_t ctl,
	output vfd_pkg::row_t          rd_row
);

	vfd_pkg::row_t                   mem [vfd_pkg::TABLE_SETS];
	logic [vfd_pkg::TABLE_SETS-1:0]  row_vld_q;
	vfd_pkg::row_t                   rd_data_q;
	logic                            rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_set] <= ctl.wr_row;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				row_vld_q[ctl.wr_set] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= row_vld_q[ctl.rd_set];
			end
		end
	end

	// a row never written reads as all ways free
	always_comb begin
		rd_row = rd_data_q;
		for (int w = 0; w < vfd_pkg::TABLE_WAYS; w++) begin
			rd_row[w].vld = rd_data_q[w].vld & rd_vld_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/vlan_fdb_forward_decider_core.sv
// a request runs: accept (hash multiply), HASH (set read), LOOK (decide, write back, load result)
// a new request is taken only in IDLE; LOOK holds while the result register is stalled
// the table is a 128-row memory, one row per set holding all ways, read and written back
// reset: asynchronous, clears the per-row valid flops and the control state
// no clearing pass: requests are taken from the first cycle after reset
`default_nettype none

module vlan_fdb_forward_decider_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vfd_req_if.sink    req,
	vfd_rsp_if.source  rsp
);

	vfd_pkg::state_t               state_q;
	vfd_pkg::state_t               state_d;
	logic                          accept;
	logic                          out_load;
	logic                          kind_q;
	logic [vfd_pkg::LEN_W-1:0]     len_q;
	logic [vfd_pkg::ETY_W-1:0]     outer_q;
	logic [vfd_pkg::ETY_W-1:0]     inner_q;
	logic [vfd_pkg::PORT_W-1:0]    wport_q;
	vfd_pkg::key_t                 key_q;
	vfd_pkg::key_t                 key_in;
	logic [vfd_pkg::TCI_W-1:0]     vid_in;
	logic [vfd_pkg::VID_W-1:0]     vid;
	vfd_pkg::set_t                 set;
	vfd_pkg::tbl_ctl_t             tbl_ctl;
	vfd_pkg::row_t                 row;
	vfd_pkg::row_t                 row_upd;
	logic                          hit;
	logic [vfd_pkg::WAY_W-1:0]     hit_idx;
	logic                          free;
	logic [vfd_pkg::WAY_W-1:0]     free_idx;
	logic                          wr_need;
	vfd_pkg::rsp_t                 res;
	vfd_pkg::rsp_t                 rsp_q;
	logic                          rsp_vld_q;

	assign accept = req.valid & req.ready;
	assign vid_in = req.payload.tag_control & vfd_pkg::VID_FIELD_MASK;
	assign key_in = req.payload.kind ? {req.payload.write_vlan, req.payload.write_mac}
		: {vid_in[vfd_pkg::VID_W-1:0], req.payload.dest_mac};

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.payload.kind;
			len_q   <= req.payload.frame_length;
			outer_q <= req.payload.outer_ethertype;
			inner_q <= req.payload.inner_ethertype;
			wport_q <= req.payload.write_port;
			key_q   <= key_in;
		end
	end

	vfd_hash u_hash (
		.clk (clk),
		.ld  (accept),
		.key (key_in),
		.set (set)
	);

	vfd_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tbl_ctl),
		.rd_row (row)
	);

	assign vid = key_q[vfd_pkg::MAC_W +: vfd_pkg::VID_W];

	// lowest matching way and lowest free way
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int w = vfd_pkg::TABLE_WAYS - 1; w >= 0; w--) begin
			if (row[w].vld && row[w].key == key_q) begin
				hit     = 1'b1;
				hit_idx = vfd_pkg::WAY_W'(w);
			end
			if (!row[w].vld) begin
				free     = 1'b1;
				free_idx = vfd_pkg::WAY_W'(w);
			end
		end
	end

	always_comb begin
		res     = '0;
		row_upd = row;
		wr_need = 1'b0;
		if (kind_q) begin
			res.verdict = vfd_pkg::VERDICT_WRITE_DONE;
			if (hit) begin
				wr_need = 1'b1;
				if (wport_q == '0) begin
					row_upd[hit_idx].vld = 1'b0;
				end else begin
					row_upd[hit_idx].port = wport_q;
				end
			end else if (wport_q != '0) begin
				if (free) begin
					wr_need = 1'b1;
					row_upd[free_idx].vld  = 1'b1;
					row_upd[free_idx].key  = key_q;
					row_upd[free_idx].port = wport_q;
				end else begin
					res.table_full = 1'b1;
				end
			end
		end else if (len_q < vfd_pkg::ETH_HDR_BYTES) begin
			res.verdict = vfd_pkg::VERDICT_DROP;
		end else if (outer_q != vfd_pkg::TPID_VLAN) begin
			res.verdict = vfd_pkg::VERDICT_PASS;
		end else if (len_q < vfd_pkg::ETH_HDR_BYTES + vfd_pkg::TAG_BYTES) begin
			res.verdict = vfd_pkg::VERDICT_DROP;
		end else if (vid != '0 && hit && row[hit_idx].port != '0) begin
			res.verdict       = vfd_pkg::VERDICT_REDIRECT;
			res.egress_port   = row[hit_idx].port;
			res.new_ethertype = inner_q;
			res.new_length    = len_q - vfd_pkg::TAG_BYTES;
		end else begin
			res.verdict = vfd_pkg::VERDICT_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req.ready      = 1'b0;
		out_load       = 1'b0;
		tbl_ctl        = '0;
		tbl_ctl.rd_set = set;
		tbl_ctl.wr_set = set;
		tbl_ctl.wr_row = row_upd;
		case (state_q)
			vfd_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = vfd_pkg::ST_HASH;
				end
			end
			vfd_pkg::ST_HASH: begin
				tbl_ctl.rd_en = 1'b1;
				state_d       = vfd_pkg::ST_LOOK;
			end
			vfd_pkg::ST_LOOK: begin
				// result register must be free before the write-back commits
				if (!rsp_vld_q || rsp.ready) begin
					out_load      = 1'b1;
					tbl_ctl.wr_en = wr_need;
					state_d       = vfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vfd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_load) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;

	a_wr_only_for_write: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.wr_en |-> kind_q)
		else $error("table written by a frame request");

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == vfd_pkg::ST_HASH)
		else $error("accepted request did not start a lookup");

	a_verdict_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ((rsp.payload.verdict == vfd_pkg::VERDICT_WRITE_DONE) == $past(kind_q)))
		else $error("verdict does not match request kind");

	a_full_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.table_full)
			|-> rsp.payload.verdict == vfd_pkg::VERDICT_WRITE_DONE)
		else $error("table full flagged on a frame result");

endmodule

`default_nettype wire
